// ----- design/assert_macros.svh -----
// assertion helpers shared by the design modules
// both expect clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0] cfg_t;

  // most negative sample, the empty-window peak
  localparam sample_t INT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } swm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_rescan;
    logic scan_done;
    logic item_prod;
    logic out_free;
  } swm_sts_t;

endpackage

`default_nettype wire

// ----- design/swm_if.sv -----
`default_nettype none

// sample channel
interface swm_sample_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// result channel
interface swm_result_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t window_max;
  logic    last_result;

  modport source (output valid, output window_max, output last_result, input ready);
  modport sink (input valid, input window_max, input last_result, output ready);
endinterface

// window size write channel
interface swm_cfg_if import swm_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t window_size;

  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// ----- design/swm_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module swm_ctrl import swm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  swm_sts_t sts,
  output swm_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.need_rescan ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts.item_prod || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SWM_ASSERT_NEXT(a_scan_to_fin, (state == ST_SCAN) && sts.scan_done, state == ST_FIN, "scan end did not reach finish")
  `SWM_ASSERT_NEXT(a_load_to_fin, cmd.load && !sts.need_rescan, state == ST_FIN, "load without rescan did not reach finish")
  `SWM_ASSERT_NEXT(a_hold_result, (state == ST_FIN) && sts.item_prod && !sts.out_free, state == ST_FIN, "result dropped while output busy")

endmodule

`default_nettype wire

// ----- design/swm_datapath.sv -----
`default_nettype none
`include "assert_macros.svh"

module swm_datapath import swm_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  input  cfg_t     cfg_data,
  input  sample_t  in_sample,
  input  logic     in_last,
  input  swm_cmd_t cmd,
  output swm_sts_t sts,
  input  logic     out_ready,
  output logic     out_valid,
  output sample_t  out_max,
  output logic     out_last
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int SW = CW + 1;
  localparam int KW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW_MAX - 1);
  localparam logic [SW-1:0] SLOT_TOP  = SW'(WINDOW_MAX - 1);
  localparam logic [SW-1:0] RING_LEN  = SW'(WINDOW_MAX);
  localparam logic [KW-1:0] K_CAP     = KW'(WINDOW_MAX);

  sample_t mem [WINDOW_MAX];

  cfg_t          window_size;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] fill_count;
  sample_t       peak;
  logic [CW-1:0] peak_age;
  logic          item_prod;
  logic          item_last;
  logic [CW-1:0] scan_left;
  logic [CW-1:0] scan_span;
  logic          rd_valid;
  sample_t       rd_data;
  logic [CW-1:0] rd_age;

  logic [KW-1:0] ws_ext;
  logic [KW-1:0] k_wide;
  logic [CW-1:0] keff;
  logic          fill_zero;
  sample_t       peak_a;
  logic [CW-1:0] age_a;
  logic [CW-1:0] fill_n;
  logic [CW-1:0] span;
  logic          new_top;
  logic          need_rescan;
  logic [CW-1:0] scan_age;
  logic [SW-1:0] slot_sum;
  logic [SW-1:0] slot_wrap;
  logic [AW-1:0] rd_addr;
  logic          scan_issue;
  logic          peak_take;

  // effective window length, clamped to 1..WINDOW_MAX
  always_comb begin
    ws_ext = KW'(window_size);
    if (window_size == '0) begin
      k_wide = KW'(1);
    end else if (ws_ext > K_CAP) begin
      k_wide = K_CAP;
    end else begin
      k_wide = ws_ext;
    end
    keff = k_wide[CW-1:0];
  end

  // per-sample peak update ahead of any rescan
  always_comb begin
    fill_zero   = (fill_count == '0);
    peak_a      = fill_zero ? in_sample : peak;
    age_a       = fill_zero ? '0 : peak_age + CW'(1);
    fill_n      = (fill_count < keff) ? fill_count + CW'(1) : fill_count;
    span        = (fill_n < keff) ? fill_n : keff;
    new_top     = (in_sample > peak_a);
    need_rescan = !new_top && (age_a >= span);
  end

  // ring slot of the sample being rescanned, oldest first
  always_comb begin
    scan_age   = scan_left - CW'(1);
    slot_sum   = SW'(write_slot) + SLOT_TOP - SW'(scan_age);
    slot_wrap  = (slot_sum >= RING_LEN) ? slot_sum - RING_LEN : slot_sum;
    rd_addr    = slot_wrap[AW-1:0];
    scan_issue = cmd.scan && (scan_left != '0);
    peak_take  = rd_valid && ((rd_age == scan_span - CW'(1)) || (rd_data > peak));
  end

  // status to controller
  always_comb begin
    sts.need_rescan = need_rescan;
    sts.scan_done   = rd_valid && (rd_age == '0);
    sts.item_prod   = item_prod;
    sts.out_free    = !out_valid || out_ready;
  end

  // sample ring, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[write_slot] <= in_sample;
    end
    if (scan_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control state and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= cfg_t'(1);
      write_slot  <= '0;
      fill_count  <= '0;
      peak        <= INT_MIN;
      peak_age    <= '0;
      item_prod   <= 1'b0;
      item_last   <= 1'b0;
      scan_left   <= '0;
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_size <= cfg_data;
      end
      rd_valid <= scan_issue;
      if (cmd.load) begin
        write_slot <= (write_slot == SLOT_LAST) ? '0 : write_slot + AW'(1);
        fill_count <= fill_n;
        item_prod  <= (fill_n >= keff);
        item_last  <= in_last;
        scan_left  <= need_rescan ? span : '0;
        if (new_top) begin
          peak     <= in_sample;
          peak_age <= '0;
        end else begin
          peak     <= peak_a;
          peak_age <= age_a;
        end
      end
      if (scan_issue) begin
        scan_left <= scan_age;
      end
      if (peak_take) begin
        peak     <= rd_data;
        peak_age <= rd_age;
      end
      if (cmd.finish && item_last) begin
        fill_count <= '0;
        peak       <= INT_MIN;
        peak_age   <= '0;
      end
      if (cmd.finish && item_prod) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_span <= span;
    end
    if (scan_issue) begin
      rd_age <= scan_age;
    end
    if (cmd.finish && item_prod) begin
      out_max  <= peak;
      out_last <= item_last;
    end
  end

  `SWM_ASSERT_NEXT(a_fill_after_load, cmd.load, fill_count != '0, "fill count zero after a sample")
  `SWM_ASSERT_NEXT(a_clear_on_last, cmd.finish && item_last, (fill_count == '0) && (peak == INT_MIN), "array end did not clear window state")
  `SWM_ASSERT_SAME(a_read_in_scan, rd_valid, $past(cmd.scan), "ring read outside a rescan")

endmodule

`default_nettype wire

// ----- design/sliding_window_max.sv -----
// Sliding-window maximum over a stream of signed 32-bit samples.
// samples: valid/ready channel carrying sample and last_sample; one word is
//   taken whenever the block is idle, independent of the result side.
// results: valid/ready channel carrying window_max and last_result; a result
//   comes out for each sample once window_size samples of the array are in.
// cfg: valid/ready write of window_size (0 acts as 1, capped at WINDOW_MAX);
//   always ready; user writes only while no sample is in work, not enforced.
// Flow: when the stored peak is still inside the window, a sample's load
//   goes straight to the finish step, which registers its result. When it
//   leaves the window the ring is rescanned first, one read per sample in
//   the window through the single memory port with a registered read.
//   A new sample is taken only once the previous one has finished.
// A stalled result waits in the output register; the next sample is still
//   taken and worked on, and its result waits in the finish step.
// last_sample ends the array: its result is flagged and the fill count,
//   peak and peak age clear for the next array.
// Reset (rst, synchronous): fill count, ring pointer and
//   peak clear and window_size returns to 1; the ring needs no clearing
//   pass since only samples of the current array are ever read.
`default_nettype none

module sliding_window_max import swm_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input logic          clk,
  input logic          rst,
  swm_cfg_if.sink      cfg,
  swm_sample_if.sink   samples,
  swm_result_if.source results
);

  swm_cmd_t cmd;
  swm_sts_t sts;
  logic     in_ready;

  // configuration is always accepted
  assign cfg.ready     = 1'b1;
  assign samples.ready = in_ready;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.window_size),
    .in_sample (samples.sample),
    .in_last   (samples.last_sample),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_max   (results.window_max),
    .out_last  (results.last_result)
  );

endmodule

`default_nettype wire
